[rtl/core/set_assoc_lru_cache_model_core_macros.svh]
// Assertion macros for the cache model core
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define SALC_ASSERT_IMP(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("set_assoc_lru_cache_model_core: check failed");

// next-cycle implication, checked on clock, off during reset
`define SALC_ASSERT_NXT(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("set_assoc_lru_cache_model_core: check failed");

`endif

[rtl/core/salc_pkg.sv]
// Shared constants, codes and types of the cache model core
package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_WIDTH   = 64;

   localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int LINE_W    = $clog2(NUM_LINES);
   localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SB_W      = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 32;

   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 6;
   localparam int WAYS_W       = 4;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam int REG_W  = 2;

   localparam logic [REG_W-1:0] REG_SET_BITS   = 2'd0;
   localparam logic [REG_W-1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [REG_W-1:0] REG_WAYS       = 2'd2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_FETCH  = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef struct packed {
      logic [SB_W-1:0]         set_bits;
      logic [BLOCK_BITS_W-1:0] block_bits;
      logic [WAY_CNT_W-1:0]    ways;
   } salc_geom_type;

   typedef struct packed {
      logic                  en;
      logic                  tag_en;
      logic [LINE_W-1:0]     addr;
      logic                  valid;
      logic [STAMP_W-1:0]    stamp;
      logic [ADDR_WIDTH-1:0] tag;
   } salc_line_wr_type;

   typedef struct packed {
      logic                  valid;
      logic [STAMP_W-1:0]    stamp;
      logic [ADDR_WIDTH-1:0] tag;
   } salc_line_rd_type;

endpackage

[rtl/core/salc_csr.sv]
// Configuration registers and effective cache geometry
module salc_csr import salc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_AW-1:0]     paddr,
   input  logic [CSR_DW-1:0]     pwdata,
   output logic [CSR_DW-1:0]     prdata,
   output logic                  pready,
   output salc_geom_type         geom
);

   logic [SET_BITS_W-1:0]   set_bits_ff, set_bits_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [WAYS_W-1:0]       ways_ff, ways_in;
   logic                    wr_en;
   logic [REG_W-1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_AW-1:2];

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SET_BITS:   set_bits_in   = pwdata[SET_BITS_W-1:0];
            REG_BLOCK_BITS: block_bits_in = pwdata[BLOCK_BITS_W-1:0];
            REG_WAYS:       ways_in       = pwdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SET_BITS:   prdata = CSR_DW'(set_bits_ff);
         REG_BLOCK_BITS: prdata = CSR_DW'(block_bits_ff);
         REG_WAYS:       prdata = CSR_DW'(ways_ff);
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         geom.set_bits = SB_W'(MAX_SET_BITS);
      end else begin
         geom.set_bits = SB_W'(set_bits_ff);
      end
      geom.block_bits = block_bits_ff;
      if (ways_ff == '0) begin
         geom.ways = WAY_CNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         geom.ways = WAY_CNT_W'(MAX_WAYS);
      end else begin
         geom.ways = WAY_CNT_W'(ways_ff);
      end
   end

endmodule

[rtl/core/salc_line_store.sv]
// Line storage: tag memory and valid/stamp memory with registered read
module salc_line_store import salc_pkg::*; (
   input  logic              clock,
   input  salc_line_wr_type  wr,
   input  logic              rd_en,
   input  logic [LINE_W-1:0] rd_addr,
   output salc_line_rd_type  rd
);

   logic [ADDR_WIDTH-1:0]  tag_mem  [NUM_LINES];
   logic [STAMP_W:0]       meta_mem [NUM_LINES];
   logic [ADDR_WIDTH-1:0]  rd_tag_ff;
   logic [STAMP_W:0]       rd_meta_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         meta_mem[wr.addr] <= {wr.valid, wr.stamp};
         if (wr.tag_en) begin
            tag_mem[wr.addr] <= wr.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff  <= tag_mem[rd_addr];
         rd_meta_ff <= meta_mem[rd_addr];
      end
   end

   assign rd.valid = rd_meta_ff[STAMP_W];
   assign rd.stamp = rd_meta_ff[STAMP_W-1:0];
   assign rd.tag   = rd_tag_ff;

endmodule

[rtl/core/set_assoc_lru_cache_model_core.sv]
// Set-associative LRU cache model core: sequencer, way scan and totals
// After reset the block runs a clearing pass over all 512 lines, one line a cycle, with busy
// high throughout; configuration writes are taken meanwhile. A fetch request is taken while
// idle and gives no result. A load or store keeps busy high while the block splits the
// address, scans the set one way a cycle through the single read port of the line store (a
// hit refreshes that line's stamp during the scan) and then, on a miss, fills or evicts the
// chosen line; a new request is taken only once busy is low again. A modify runs two such
// accesses. Each result is shown for one cycle with rsp_valid and cannot be stalled; the
// running totals on rsp_*_total already include that access.
module set_assoc_lru_cache_model_core import salc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [63:0]       req_address,
   output logic              rsp_valid,
   output logic [1:0]        rsp_outcome,
   output logic              rsp_last,
   output logic [31:0]       rsp_hit_total,
   output logic [31:0]       rsp_miss_total,
   output logic [31:0]       rsp_evict_total,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam int TOT_W = BLOCK_BITS_W + 1;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [LINE_W-1:0] line_idx(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
      return LINE_W'(s) * LINE_W'(MAX_WAYS) + LINE_W'(w);
   endfunction

   salc_geom_type    geom;
   salc_line_wr_type line_wr;
   salc_line_rd_type line_rd;
   logic             rd_en;
   logic [LINE_W-1:0] rd_addr;

   logic [2:0]            state_ff, state_in;
   logic [LINE_W-1:0]     clr_ff, clr_in;
   logic                  more_ff, more_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [STAMP_W-1:0]    use_clock_ff, use_clock_in;
   logic [CNT_W-1:0]      hit_count_ff, hit_count_in;
   logic [CNT_W-1:0]      miss_count_ff, miss_count_in;
   logic [CNT_W-1:0]      evict_count_ff, evict_count_in;
   logic [WAY_CNT_W-1:0]  issue_ff, issue_in;
   logic                  dv_ff, dv_in;
   logic [WAY_W-1:0]      dway_ff, dway_in;
   logic                  hit_ff, hit_in;
   logic                  empty_ff, empty_in;
   logic [WAY_W-1:0]      empty_way_ff, empty_way_in;
   logic [WAY_W-1:0]      victim_ff, victim_in;
   logic [STAMP_W-1:0]    min_ff, min_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            outcome_ff, outcome_in;
   logic                  last_ff, last_in;

   logic [ADDR_WIDTH-1:0] set_shift;
   logic [ADDR_WIDTH-1:0] tag_shift;
   logic [TOT_W-1:0]      tag_amt;
   logic [SET_W-1:0]      set_mask;
   logic                  way_match;
   logic                  last_way;

   salc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .geom    (geom)
   );

   salc_line_store u_store (
      .clock   (clock),
      .wr      (line_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd      (line_rd)
   );

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      tag_amt   = TOT_W'(geom.block_bits) + TOT_W'(geom.set_bits);
      set_shift = (int'(geom.block_bits) >= ADDR_WIDTH) ? '0 : (addr_ff >> geom.block_bits);
      tag_shift = (int'(tag_amt) >= ADDR_WIDTH) ? '0 : (addr_ff >> tag_amt);
      set_mask  = ~(SET_W'('1) << geom.set_bits);
   end

   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < geom.ways);
   assign rd_addr   = line_idx(set_ff, issue_ff[WAY_W-1:0]);
   assign way_match = line_rd.valid && (line_rd.tag == tag_ff);
   assign last_way  = (WAY_CNT_W'(dway_ff) == geom.ways - WAY_CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      more_in        = more_ff;
      addr_in        = addr_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      use_clock_in   = use_clock_ff;
      hit_count_in   = hit_count_ff;
      miss_count_in  = miss_count_ff;
      evict_count_in = evict_count_ff;
      issue_in       = issue_ff;
      dv_in          = rd_en;
      dway_in        = issue_ff[WAY_W-1:0];
      hit_in         = hit_ff;
      empty_in       = empty_ff;
      empty_way_in   = empty_way_ff;
      victim_in      = victim_ff;
      min_in         = min_ff;
      rsp_valid_in   = 1'b0;
      outcome_in     = outcome_ff;
      last_in        = last_ff;
      line_wr        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            line_wr.en   = 1'b1;
            line_wr.addr = clr_ff;
            clr_in       = clr_ff + LINE_W'(1);
            if (clr_ff == LINE_W'(NUM_LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && (req_op != OP_FETCH)) begin
               addr_in  = req_address[ADDR_WIDTH-1:0];
               more_in  = (req_op == OP_MODIFY);
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            set_in       = set_shift[SET_W-1:0] & set_mask;
            tag_in       = tag_shift;
            use_clock_in = use_clock_ff + STAMP_W'(1);
            issue_in     = '0;
            hit_in       = 1'b0;
            empty_in     = 1'b0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + WAY_CNT_W'(1);
            end
            if (dv_ff) begin
               if (line_rd.valid) begin
                  if (way_match) begin
                     hit_in        = 1'b1;
                     line_wr.en    = 1'b1;
                     line_wr.addr  = line_idx(set_ff, dway_ff);
                     line_wr.valid = 1'b1;
                     line_wr.stamp = use_clock_ff;
                  end
               end else begin
                  empty_in     = 1'b1;
                  empty_way_in = dway_ff;
               end
               if ((dway_ff == '0) || (line_rd.stamp <= min_ff)) begin
                  min_in    = line_rd.stamp;
                  victim_in = dway_ff;
               end
               if (last_way) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            last_in      = !more_ff;
            if (hit_ff) begin
               hit_count_in = sat_inc(hit_count_ff);
               outcome_in   = OUT_HIT;
            end else begin
               miss_count_in  = sat_inc(miss_count_ff);
               line_wr.en     = 1'b1;
               line_wr.tag_en = 1'b1;
               line_wr.valid  = 1'b1;
               line_wr.stamp  = use_clock_ff;
               line_wr.tag    = tag_ff;
               if (empty_ff) begin
                  line_wr.addr = line_idx(set_ff, empty_way_ff);
                  outcome_in   = OUT_FILL;
               end else begin
                  line_wr.addr   = line_idx(set_ff, victim_ff);
                  evict_count_in = sat_inc(evict_count_ff);
                  outcome_in     = OUT_EVICT;
               end
            end
            if (more_ff) begin
               more_in  = 1'b0;
               state_in = ST_PREP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         more_ff        <= 1'b0;
         use_clock_ff   <= '0;
         hit_count_ff   <= '0;
         miss_count_ff  <= '0;
         evict_count_ff <= '0;
         issue_ff       <= '0;
         dv_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         more_ff        <= more_in;
         use_clock_ff   <= use_clock_in;
         hit_count_ff   <= hit_count_in;
         miss_count_ff  <= miss_count_in;
         evict_count_ff <= evict_count_in;
         issue_ff       <= issue_in;
         dv_ff          <= dv_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      dway_ff      <= dway_in;
      hit_ff       <= hit_in;
      empty_ff     <= empty_in;
      empty_way_ff <= empty_way_in;
      victim_ff    <= victim_in;
      min_ff       <= min_in;
      outcome_ff   <= outcome_in;
      last_ff      <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_last        = last_ff;
   assign rsp_hit_total   = hit_count_ff;
   assign rsp_miss_total  = miss_count_ff;
   assign rsp_evict_total = evict_count_ff;

`include "set_assoc_lru_cache_model_core_macros.svh"

   `SALC_ASSERT_NXT(a_decide_strobe, state_ff == ST_DECIDE, rsp_valid)
   `SALC_ASSERT_IMP(a_strobe_single, rsp_valid, !rsp_valid_in)
   `SALC_ASSERT_IMP(a_pair_follows, rsp_valid && !rsp_last, state_ff == ST_PREP)
   `SALC_ASSERT_IMP(a_idle_quiet, state_ff == ST_IDLE, !dv_ff && !line_wr.en)

endmodule

[bench/tb.sv]
// Testbench for the cache core: directed table, then random traces checked by a predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import salc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 13;
   localparam int PHASE_ITEMS = 95;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic [1:0]  outcome;
      logic        last;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } cache_result_type;

   typedef struct {
      bit                is_cfg;
      logic [REG_W-1:0]  reg_idx;
      logic [31:0]       reg_val;
      logic [1:0]        op;
      logic [63:0]       addr;
      bit                typed;
      cache_result_type  tres;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_op = OP_LOAD;
   logic [63:0]       req_address = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_outcome;
   logic              rsp_last;
   logic [31:0]       rsp_hit_total;
   logic [31:0]       rsp_miss_total;
   logic [31:0]       rsp_evict_total;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   bit                typed_row = 1'b0;
   cache_result_type  typed_result = '{default: '0};

   logic [63:0]       tag_ram [NUM_LINES];
   logic              valid_ram [NUM_LINES];
   logic [31:0]       stamp_ram [NUM_LINES];
   logic [31:0]       access_clock;
   logic [31:0]       hit_tally;
   logic [31:0]       miss_tally;
   logic [31:0]       evict_tally;
   logic [2:0]        geo_set_bits;
   logic [5:0]        geo_block_bits;
   logic [3:0]        geo_ways;

   cache_result_type  outcome_queue [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   stim_row_type      directed_rows [$];

   set_assoc_lru_cache_model_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_outcome     (rsp_outcome),
      .rsp_last        (rsp_last),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("set_assoc_lru_cache_model_core test failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [1:0] access_line(input logic [63:0] addr);
      int          sb;
      int          nw;
      int          bb;
      int          base;
      int          empty_way;
      int          victim;
      bit          hit;
      bit          empty;
      logic [63:0] set_idx;
      logic [63:0] tag;
      logic [31:0] smallest;
      sb = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(geo_set_bits);
      nw = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways));
      bb = int'(geo_block_bits);
      set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
      tag = (bb + sb >= 64) ? 64'd0 : (addr >> (bb + sb));
      base = int'(set_idx) * MAX_WAYS;
      hit = 1'b0;
      empty = 1'b0;
      empty_way = 0;
      access_clock = access_clock + 32'd1;
      for (int w = 0; w < nw; w++) begin
         if (valid_ram[base + w]) begin
            if (tag_ram[base + w] == tag) begin
               hit = 1'b1;
               stamp_ram[base + w] = access_clock;
            end
         end else begin
            empty = 1'b1;
            empty_way = w;
         end
      end
      if (hit) begin
         hit_tally = sat_inc(hit_tally);
         return OUT_HIT;
      end
      miss_tally = sat_inc(miss_tally);
      if (empty) begin
         valid_ram[base + empty_way] = 1'b1;
         tag_ram[base + empty_way] = tag;
         stamp_ram[base + empty_way] = access_clock;
         return OUT_FILL;
      end
      victim = 0;
      smallest = stamp_ram[base];
      for (int w = 0; w < nw; w++) begin
         if (stamp_ram[base + w] <= smallest) begin
            smallest = stamp_ram[base + w];
            victim = w;
         end
      end
      tag_ram[base + victim] = tag;
      stamp_ram[base + victim] = access_clock;
      evict_tally = sat_inc(evict_tally);
      return OUT_EVICT;
   endfunction

   function automatic void predict_request(input logic [1:0] op, input logic [63:0] addr);
      logic [1:0] oc;
      int         n;
      n = (op == OP_FETCH) ? 0 : ((op == OP_MODIFY) ? 2 : 1);
      for (int k = 0; k < n; k++) begin
         oc = access_line(addr);
         outcome_queue.push_back('{oc, (k == n - 1), hit_tally, miss_tally, evict_tally});
      end
   endfunction

   always @(posedge clock) begin
      cache_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            valid_ram[i] = 1'b0;
            stamp_ram[i] = '0;
            tag_ram[i] = '0;
         end
         access_clock = '0;
         hit_tally = '0;
         miss_tally = '0;
         evict_tally = '0;
         geo_set_bits = 3'd0;
         geo_block_bits = 6'd0;
         geo_ways = 4'd1;
         outcome_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (outcome_queue.size() == 0) begin
               report_mismatch("unexpected result", 64'(rsp_outcome), 64'd0);
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_outcome !== want.outcome)
                  report_mismatch("outcome", 64'(rsp_outcome), 64'(want.outcome));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
               if (rsp_hit_total !== want.hits)
                  report_mismatch("hit_total", 64'(rsp_hit_total), 64'(want.hits));
               if (rsp_miss_total !== want.misses)
                  report_mismatch("miss_total", 64'(rsp_miss_total), 64'(want.misses));
               if (rsp_evict_total !== want.evicts)
                  report_mismatch("evict_total", 64'(rsp_evict_total), 64'(want.evicts));
            end
         end
         if (start && !busy) begin
            predict_request(req_op, req_address);
            if (typed_row) begin
               void'(outcome_queue.pop_back());
               outcome_queue.push_back(typed_result);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               {REG_SET_BITS, 2'b00}:   geo_set_bits = pwdata[2:0];
               {REG_BLOCK_BITS, 2'b00}: geo_block_bits = pwdata[5:0];
               {REG_WAYS, 2'b00}:       geo_ways = pwdata[3:0];
               default: ;
            endcase
         end
      end
   end

   task automatic issue_request(input logic [1:0] op, input logic [63:0] addr,
                                input bit typed, input cache_result_type tres);
      start <= 1'b1;
      req_op <= op;
      req_address <= addr;
      typed_row <= typed;
      typed_result <= tres;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while ((outcome_queue.size() != 0 || busy) && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outcome_queue.size() != 0) begin
         report_mismatch("missing results", 64'd0, 64'(outcome_queue.size()));
         outcome_queue.delete();
      end
   endtask

   task automatic write_reg(input logic [REG_W-1:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type req_row(input logic [1:0] op, input logic [63:0] addr);
      stim_row_type r;
      r = '{default: '0};
      r.op = op;
      r.addr = addr;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input logic [1:0] op, input logic [63:0] addr,
                                                input logic [1:0] oc, input logic [31:0] h,
                                                input logic [31:0] m, input logic [31:0] e);
      stim_row_type r;
      r = req_row(op, addr);
      r.typed = 1'b1;
      r.tres = '{oc, 1'b1, h, m, e};
      return r;
   endfunction

   function automatic stim_row_type cfg_row(input logic [REG_W-1:0] idx,
                                            input logic [31:0] val);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   initial begin
      stim_row_type     row;
      cache_result_type no_result;
      logic [63:0]      addr_pool [24];
      logic [63:0]      offset_mask;
      logic [63:0]      addr;
      logic [1:0]       op;
      logic [5:0]       bb;
      int               pool_size;
      int               pick;
      bit               idle_on;
      no_result = '{default: '0};

      // one set, one way: every new tag replaces the single line
      directed_rows.push_back(checked_row(OP_LOAD, 64'd0, OUT_FILL, 0, 1, 0));
      directed_rows.push_back(checked_row(OP_LOAD, 64'd0, OUT_HIT, 1, 1, 0));
      directed_rows.push_back(checked_row(OP_STORE, '1, OUT_EVICT, 1, 2, 1));
      directed_rows.push_back(req_row(OP_MODIFY, '1));
      directed_rows.push_back(req_row(OP_FETCH, 64'd0));
      directed_rows.push_back(checked_row(OP_LOAD, 64'd0, OUT_EVICT, 3, 3, 2));
      directed_rows.push_back(req_row(OP_MODIFY, 64'h5555_5555_5555_5555));
      // saturated geometry, offset reaching bit 62 and the set index at the top bit
      directed_rows.push_back(cfg_row(REG_SET_BITS, 32'd7));
      directed_rows.push_back(cfg_row(REG_BLOCK_BITS, 32'd63));
      directed_rows.push_back(cfg_row(REG_WAYS, 32'd15));
      directed_rows.push_back(req_row(OP_LOAD, 64'd0));
      directed_rows.push_back(req_row(OP_LOAD, 64'h8000_0000_0000_0000));
      directed_rows.push_back(req_row(OP_STORE, '1));
      // zero ways, tag shift of exactly 64
      directed_rows.push_back(cfg_row(REG_WAYS, 32'd0));
      directed_rows.push_back(cfg_row(REG_SET_BITS, 32'd6));
      directed_rows.push_back(cfg_row(REG_BLOCK_BITS, 32'd58));
      directed_rows.push_back(req_row(OP_LOAD, '1));
      directed_rows.push_back(req_row(OP_MODIFY, 64'h03FF_FFFF_FFFF_FFFF));
      // duplicate tags across a ways change, then an equal-stamp victim choice
      directed_rows.push_back(cfg_row(REG_SET_BITS, 32'd0));
      directed_rows.push_back(cfg_row(REG_BLOCK_BITS, 32'd0));
      directed_rows.push_back(cfg_row(REG_WAYS, 32'd2));
      directed_rows.push_back(req_row(OP_LOAD, 64'h1234));
      directed_rows.push_back(cfg_row(REG_WAYS, 32'd1));
      directed_rows.push_back(req_row(OP_LOAD, 64'h1234));
      directed_rows.push_back(cfg_row(REG_WAYS, 32'd2));
      directed_rows.push_back(req_row(OP_LOAD, 64'h1234));
      directed_rows.push_back(req_row(OP_LOAD, 64'h9999));
      directed_rows.push_back(req_row(OP_LOAD, 64'h1234));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            settle();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            issue_request(row.op, row.addr, row.typed, row.tres);
         end
      end

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         settle();
         bb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 6));
         write_reg(REG_SET_BITS, ($urandom() & ~32'h7) | 32'($urandom_range(0, 7)));
         write_reg(REG_BLOCK_BITS, ($urandom() & ~32'h3F) | 32'(bb));
         write_reg(REG_WAYS, ($urandom() & ~32'hF) | 32'($urandom_range(0, 15)));
         offset_mask = (64'd1 << bb) - 64'd1;
         pool_size = $urandom_range(4, 24);
         for (int k = 0; k < pool_size; k++)
            addr_pool[k] = {$urandom(), $urandom()};
         idle_on = (phase != RAND_PHASES - 1) && ($urandom_range(0, 2) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2: op = OP_LOAD;
               3, 4, 5: op = OP_STORE;
               6, 7, 8: op = OP_MODIFY;
               default: op = OP_FETCH;
            endcase
            if ($urandom_range(0, 6) == 0)
               addr = {$urandom(), $urandom()};
            else
               addr = addr_pool[$urandom_range(0, pool_size - 1)]
                      ^ ({$urandom(), $urandom()} & offset_mask);
            issue_request(op, addr, 1'b0, no_result);
            if (idle_on && $urandom_range(0, 3) == 0)
               idle_gap($urandom_range(1, 7));
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("set_assoc_lru_cache_model_core test passed");
      end else begin
         $display("set_assoc_lru_cache_model_core test failed");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/salc_pkg.sv
rtl/core/salc_csr.sv
rtl/core/salc_line_store.sv
rtl/core/set_assoc_lru_cache_model_core.sv
bench/tb.sv
